[hdl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, register indexes and constants of the Mandelbrot escape unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int MAX_DIM_DEF   = 1024;
  localparam int FRAC_BITS_DEF = 28;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd5;

  localparam logic [2:0]         QUALITY_RST    = 3'd0;
  localparam logic signed [31:0] X_START_RST    = -32'sd536870912;
  localparam logic signed [31:0] Y_START_RST    = 32'sd335544320;
  localparam logic [30:0]        STEP_X_RST     = 31'd1677722;
  localparam logic [30:0]        STEP_Y_RST     = 31'd1398101;
  localparam logic [10:0]        LINE_WIDTH_RST = 11'd480;

  // Color conversion weights.
  localparam logic [7:0] Y_R = 8'd77;
  localparam logic [7:0] Y_G = 8'd150;
  localparam logic [7:0] Y_B = 8'd29;
  localparam logic [7:0] C_112 = 8'd112;
  localparam logic [7:0] CB_G = 8'd74;
  localparam logic [7:0] CB_R = 8'd38;
  localparam logic [7:0] CR_G = 8'd94;
  localparam logic [7:0] CR_B = 8'd18;
  localparam logic [7:0] CHAN_MIN = 8'd16;
  localparam logic [7:0] CHAN_MAX = 8'd240;
  localparam logic [7:0] MOD_BASE = 8'd255;

  // Point, limit and framebuffer index of one pixel, handed to the iterator.
  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic [23:0]        limit;
    logic [19:0]        fb_index;
  } item_t;

  function automatic logic [23:0] limit_of(input logic [2:0] q);
    logic [23:0] l;
    case (q)
      3'd0:    l = 24'h0000ff;
      3'd1:    l = 24'h000fff;
      3'd2:    l = 24'h00ffff;
      3'd3:    l = 24'h0fffff;
      default: l = 24'hffffff;
    endcase
    return l;
  endfunction

endpackage

[hdl/mbe_front.sv]
// ----------------------------------------------------------------------------
// mbe_front
// Holds the configuration, takes pixel commands and forms the point c, the
// iteration limit and the framebuffer index for the iterator queue.
// ----------------------------------------------------------------------------
module mbe_front #(
  parameter int MAX_DIM = mbe_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            start,
  input  logic [9:0]                      pixel_col,
  input  logic [9:0]                      pixel_row,
  output logic                            busy,
  input  logic                            q_full,
  output logic                            q_push,
  output mbe_pkg::item_t                  q_item
);

  localparam logic [9:0] COORD_MAX = 10'(MAX_DIM - 1);

  logic [2:0]         quality_r;
  logic signed [31:0] x_start_r;
  logic signed [31:0] y_start_r;
  logic [30:0]        step_x_r;
  logic [30:0]        step_y_r;
  logic [10:0]        line_width_r;

  logic               p_valid_r;
  logic [40:0]        prod_x_r;
  logic [40:0]        prod_y_r;
  logic [19:0]        idx_r;
  logic [23:0]        limit_r;

  logic               accept;
  logic [9:0]         col_c;
  logic [9:0]         row_c;
  logic [21:0]        idx_full;
  logic signed [42:0] sum_x;
  logic signed [42:0] sum_y;

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) r = 32'sh7fffffff;
    else if (v < -43'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  assign busy   = p_valid_r && q_full;
  assign accept = start && !busy;
  assign q_push = p_valid_r && !q_full;

  always_comb begin
    col_c = (32'(pixel_col) >= 32'(MAX_DIM)) ? COORD_MAX : pixel_col;
    row_c = (32'(pixel_row) >= 32'(MAX_DIM)) ? COORD_MAX : pixel_row;
    idx_full = 22'(row_c * line_width_r) + 22'(col_c);
  end

  always_comb begin
    sum_x = 43'(x_start_r) + $signed({2'b00, prod_x_r});
    sum_y = 43'(y_start_r) - $signed({2'b00, prod_y_r});
    q_item.cr       = sat32(sum_x);
    q_item.ci       = sat32(sum_y);
    q_item.limit    = limit_r;
    q_item.fb_index = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_r    <= mbe_pkg::QUALITY_RST;
      x_start_r    <= mbe_pkg::X_START_RST;
      y_start_r    <= mbe_pkg::Y_START_RST;
      step_x_r     <= mbe_pkg::STEP_X_RST;
      step_y_r     <= mbe_pkg::STEP_Y_RST;
      line_width_r <= mbe_pkg::LINE_WIDTH_RST;
      p_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mbe_pkg::CFG_QUALITY:    quality_r    <= cfg_wdata[2:0];
          mbe_pkg::CFG_X_START:    x_start_r    <= cfg_wdata;
          mbe_pkg::CFG_Y_START:    y_start_r    <= cfg_wdata;
          mbe_pkg::CFG_STEP_X:     step_x_r     <= cfg_wdata[30:0];
          mbe_pkg::CFG_STEP_Y:     step_y_r     <= cfg_wdata[30:0];
          mbe_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (accept) p_valid_r <= 1'b1;
      else if (q_push) p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x_r <= 41'(col_c * step_x_r);
      prod_y_r <= 41'(row_c * step_y_r);
      idx_r    <= idx_full[19:0];
      limit_r  <= mbe_pkg::limit_of(quality_r);
    end
  end

endmodule

[hdl/mbe_queue.sv]
// ----------------------------------------------------------------------------
// mbe_queue
// Two-entry register queue between the command front and the iterator.
// ----------------------------------------------------------------------------
module mbe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbe_pkg::item_t wr_item,
  input  logic           pop,
  output mbe_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);

  mbe_pkg::item_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

[hdl/mbe_back.sv]
// ----------------------------------------------------------------------------
// mbe_back
// Escape-time iterator and color converter. Three multiplier lanes form
// x*x, y*y and x*y from half-width partial products, accumulated step by step.
// ----------------------------------------------------------------------------
module mbe_back #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mbe_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  output logic [31:0]    out_pixel_word,
  output logic [23:0]    out_iteration_count,
  output logic           out_inside_set,
  output logic [19:0]    out_fb_index
);

  localparam int ZB = 12 + FRAC_BITS;
  localparam int H  = (ZB + 1) / 2;
  localparam int AW = 4 * H;
  localparam int WS = ((ZB > 32) ? ZB : 32) + 2;

  localparam logic signed [ZB-1:0] ZMAX_Z = {1'b0, {(ZB-1){1'b1}}};
  localparam logic signed [ZB-1:0] ZMIN_Z = {1'b1, {(ZB-1){1'b0}}};
  localparam logic signed [WS-1:0] ZMAX_S = (WS'(1) << (ZB - 1)) - WS'(1);
  localparam logic signed [WS-1:0] ZMIN_S = ~ZMAX_S;
  localparam logic [AW-1:0]        ZMAX_A = (AW'(1) << (ZB - 1)) - AW'(1);
  localparam logic [ZB:0]          FOUR   = (ZB+1)'(1) << (FRAC_BITS + 2);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TEST = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_SAT  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_COL1 = 7'b0100000,
    S_COL2 = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [ZB-1:0] x_r, y_r, xs_r, ys_r, t_r;
  logic signed [31:0]   cr_r, ci_r;
  logic [23:0]          limit_r, n_r;
  logic [19:0]          idx_r;
  logic [2*H-1:0]       am_r [3];
  logic [2*H-1:0]       bm_r [3];
  logic                 neg_r [3];
  logic [AW-1:0]        acc_r [3];
  logic [1:0]           step_r;
  logic [7:0]           r_r, g_r, b_r;
  logic                 inside_r;

  logic                 out_valid_r;
  logic [31:0]          word_r;

  logic [ZB:0]          mag_sum;
  logic                 go_on;
  logic [AW-1:0]        pp [3];
  logic signed [WS-1:0] x_sum, y_sum;
  logic                 at_limit;
  logic [7:0]           r_c, g_c, b_c;
  logic [15:0]          y_acc;
  logic signed [19:0]   cb_s, cr_s;
  logic [7:0]           yv, cbv, crv;

  function automatic logic [2*H-1:0] mag(input logic signed [ZB-1:0] v);
    logic [ZB-1:0] m;
    m = v[ZB-1] ? ZB'(-v) : ZB'(v);
    return (2*H)'(m);
  endfunction

  // Scales a magnitude product and restores its sign, saturating.
  function automatic logic signed [ZB-1:0] scale(input logic [AW-1:0] acc, input logic neg,
                                                 input int sh);
    logic [AW-1:0]        m;
    logic signed [ZB-1:0] r;
    m = acc >> sh;
    if (m > ZMAX_A) r = neg ? ZMIN_Z : ZMAX_Z;
    else r = neg ? -$signed(m[ZB-1:0]) : $signed(m[ZB-1:0]);
    return r;
  endfunction

  function automatic logic signed [ZB-1:0] clampz(input logic signed [WS-1:0] v);
    logic signed [ZB-1:0] r;
    if (v > ZMAX_S) r = ZMAX_Z;
    else if (v < ZMIN_S) r = ZMIN_Z;
    else r = v[ZB-1:0];
    return r;
  endfunction

  // Remainder by 255: bytes are folded since 256 is one modulo 255.
  function automatic logic [7:0] mod255(input logic [26:0] v);
    logic [9:0] s1;
    logic [8:0] s2;
    s1 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[26:24]);
    s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
    if (s2 >= 9'(mbe_pkg::MOD_BASE)) s2 = s2 - 9'(mbe_pkg::MOD_BASE);
    return s2[7:0];
  endfunction

  function automatic logic [7:0] clamp_chan(input logic [7:0] v);
    logic [7:0] r;
    if (v < mbe_pkg::CHAN_MIN) r = mbe_pkg::CHAN_MIN;
    else if (v > mbe_pkg::CHAN_MAX) r = mbe_pkg::CHAN_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [7:0] chroma(input logic signed [19:0] v);
    logic signed [19:0] q;
    q = v[19] ? ((v + 20'sd511) >>> 9) : (v >>> 9);
    q = q + 20'sd128;
    return q[7:0];
  endfunction

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    mag_sum = {1'b0, xs_r} + {1'b0, ys_r};
    go_on   = (n_r < limit_r) && (mag_sum < FOUR);
    x_sum   = WS'(xs_r) - WS'(ys_r) + WS'(cr_r);
    y_sum   = WS'(t_r) + WS'(ci_r);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (step_r)
        2'd0:    pp[i] = AW'(am_r[i][H-1:0] * bm_r[i][H-1:0]);
        2'd1:    pp[i] = AW'(am_r[i][H-1:0] * bm_r[i][2*H-1:H]) << H;
        2'd2:    pp[i] = AW'(am_r[i][2*H-1:H] * bm_r[i][H-1:0]) << H;
        default: pp[i] = AW'(am_r[i][2*H-1:H] * bm_r[i][2*H-1:H]) << (2 * H);
      endcase
    end
  end

  always_comb begin
    at_limit = (n_r == limit_r);
    if (at_limit) begin
      r_c = 8'd0;
      g_c = 8'd0;
      b_c = 8'd0;
    end else begin
      r_c = mod255({3'b000, n_r} * 27'd5);
      g_c = mod255({3'b000, n_r} * 27'd3);
      b_c = mod255({3'b000, n_r});
    end
  end

  always_comb begin
    y_acc = 16'(mbe_pkg::Y_R * r_r) + 16'(mbe_pkg::Y_G * g_r) + 16'(mbe_pkg::Y_B * b_r);
    cb_s  = $signed(20'(mbe_pkg::C_112 * {b_r, 1'b0})) - $signed(20'(mbe_pkg::CB_G * {g_r, 1'b0}))
          - $signed(20'(mbe_pkg::CB_R * {r_r, 1'b0}));
    cr_s  = $signed(20'(mbe_pkg::C_112 * {r_r, 1'b0})) - $signed(20'(mbe_pkg::CR_G * {g_r, 1'b0}))
          - $signed(20'(mbe_pkg::CR_B * {b_r, 1'b0}));
    yv    = y_acc[15:8];
    cbv   = chroma(cb_s);
    crv   = chroma(cr_s);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_TEST;
      S_TEST:  state_nxt = go_on ? S_MUL : S_COL1;
      S_MUL:   if (step_r == 2'd3) state_nxt = S_SAT;
      S_SAT:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_TEST;
      S_COL1:  state_nxt = S_COL2;
      S_COL2:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_COL2);
      if (state_r == S_MUL) step_r <= step_r + 2'd1;
      else step_r <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          cr_r    <= q_item.cr;
          ci_r    <= q_item.ci;
          limit_r <= q_item.limit;
          idx_r   <= q_item.fb_index;
          x_r     <= '0;
          y_r     <= '0;
          xs_r    <= '0;
          ys_r    <= '0;
          n_r     <= '0;
        end
      end
      S_TEST: begin
        am_r[0]  <= mag(x_r);
        bm_r[0]  <= mag(x_r);
        neg_r[0] <= 1'b0;
        am_r[1]  <= mag(y_r);
        bm_r[1]  <= mag(y_r);
        neg_r[1] <= 1'b0;
        am_r[2]  <= mag(x_r);
        bm_r[2]  <= mag(y_r);
        neg_r[2] <= x_r[ZB-1] ^ y_r[ZB-1];
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end
      S_MUL: begin
        for (int i = 0; i < 3; i++) acc_r[i] <= acc_r[i] + pp[i];
      end
      S_SAT: begin
        xs_r <= scale(acc_r[0], neg_r[0], FRAC_BITS);
        ys_r <= scale(acc_r[1], neg_r[1], FRAC_BITS);
        t_r  <= scale(acc_r[2], neg_r[2], FRAC_BITS - 1);
      end
      S_UPD: begin
        x_r <= clampz(x_sum);
        y_r <= clampz(y_sum);
        n_r <= n_r + 24'd1;
      end
      S_COL1: begin
        r_r      <= clamp_chan(r_c);
        g_r      <= clamp_chan(g_c);
        b_r      <= clamp_chan(b_c);
        inside_r <= at_limit;
      end
      S_COL2: begin
        word_r <= {yv, cbv, yv, crv};
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_word      = word_r;
  assign out_iteration_count = n_r;
  assign out_inside_set      = inside_r;
  assign out_fb_index        = idx_r;

endmodule

[hdl/mandelbrot_escape_pixel_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// Escape-time Mandelbrot pixel evaluator producing packed Y Cb Y Cr words.
//
//   channel  ports                                     handshake
//   input    in_pixel_col, in_pixel_row                start high, busy low
//   result   out_pixel_word, out_iteration_count,      out_valid, one cycle
//            out_inside_set, out_fb_index
//   config   cfg_index, cfg_wdata                      cfg_we
//
// Each iteration is a test state, the partial-product steps of the three
// multiplier lanes, a scaling state and an update state; out_valid rises
// after the color states that follow the last test.
// Reset is synchronous and active low and restores the default view.
// The front takes a new pixel while the iterator works, up to two queued and
// one held in the front; busy rises when the queue is full and the front
// holds a pixel. Results cannot be stalled.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_unit #(
  parameter int MAX_DIM   = mbe_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [9:0]                     in_pixel_col,
  input  logic [9:0]                     in_pixel_row,
  output logic                           out_valid,
  output logic [31:0]                    out_pixel_word,
  output logic [23:0]                    out_iteration_count,
  output logic                           out_inside_set,
  output logic [19:0]                    out_fb_index
);

  logic           q_push, q_pop, q_full, q_empty;
  mbe_pkg::item_t q_wr_item, q_rd_item;

  mbe_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .pixel_col (in_pixel_col),
    .pixel_row (in_pixel_row),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  mbe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  mbe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (q_rd_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_pixel_word      (out_pixel_word),
    .out_iteration_count (out_iteration_count),
    .out_inside_set      (out_inside_set),
    .out_fb_index        (out_fb_index)
  );

  // Points inside the set are painted with clamped black.
  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_set |-> out_pixel_word == 32'h10801080)
    else $error("inside pixel not black");

  // Every pixel runs at least one iteration.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iteration_count != 24'd0)
    else $error("zero iteration count");

  // Results never come in adjacent cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The front only stalls when the queue cannot take its pixel.
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_full && !q_push)
    else $error("busy without a full queue");

endmodule

[tb/mandelbrot_escape_pixel_checker.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_checker
// Watches the configuration, pixel and result ports of the escape unit. It
// keeps its own copy of the view registers, computes the escape count, color
// word and framebuffer index of every accepted pixel, and compares each result
// word field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           start,
  input  logic                           busy,
  input  logic [9:0]                     in_pixel_col,
  input  logic [9:0]                     in_pixel_row,
  input  logic                           out_valid,
  input  logic [31:0]                    out_pixel_word,
  input  logic [23:0]                    out_iteration_count,
  input  logic                           out_inside_set,
  input  logic [19:0]                    out_fb_index,
  output int                             failures,
  output int                             pending
);

  localparam int     FRAC = mbe_pkg::FRAC_BITS_DEF;
  localparam longint ZMAX = (64'sd1 <<< (12 + FRAC - 1)) - 1;
  localparam longint ZMIN = -ZMAX - 1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    logic [31:0] pixel_word;
    logic [23:0] iteration_count;
    logic        inside_set;
    logic [19:0] fb_index;
  } pixel_result_t;

  logic [2:0]  quality;
  longint      view_x0, view_y0, view_dx, view_dy;
  logic [10:0] words_per_line;

  pixel_result_t predicted_pixels[$];

  function automatic longint sat_z(input longint v);
    return v < ZMIN ? ZMIN : (v > ZMAX ? ZMAX : v);
  endfunction

  // Magnitude product shifted toward zero, then saturated with the sign.
  function automatic longint scaled_product(input longint a, input longint b, input int sh);
    logic         neg;
    logic [127:0] ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = {64'd0, (a < 0) ? -a : a};
    ub = {64'd0, (b < 0) ? -b : b};
    p = (ua * ub) >> sh;
    if (p > ZMAX) return neg ? ZMIN : ZMAX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic int chan_clamp(input int v);
    return v < int'(mbe_pkg::CHAN_MIN) ? int'(mbe_pkg::CHAN_MIN) :
           (v > int'(mbe_pkg::CHAN_MAX) ? int'(mbe_pkg::CHAN_MAX) : v);
  endfunction

  function automatic pixel_result_t escape_pixel(input logic [9:0] col, input logic [9:0] row);
    pixel_result_t res;
    int unsigned   lim, n;
    longint        cr, ci, x, y, sx, sy, t;
    int            r, g, b, yv, cbn, crn;
    case (quality)
      3'd0:    lim = 32'h0000ff;
      3'd1:    lim = 32'h000fff;
      3'd2:    lim = 32'h00ffff;
      3'd3:    lim = 32'h0fffff;
      default: lim = 32'hffffff;
    endcase
    cr = view_x0 + longint'(col) * view_dx;
    ci = view_y0 - longint'(row) * view_dy;
    cr = cr < I32_MIN ? I32_MIN : (cr > I32_MAX ? I32_MAX : cr);
    ci = ci < I32_MIN ? I32_MIN : (ci > I32_MAX ? I32_MAX : ci);
    x = 0; y = 0; sx = 0; sy = 0; n = 0;
    // The escape test uses the squares of the previous iterate.
    while (n < lim && sx + sy < (64'sd4 <<< FRAC)) begin
      sx = scaled_product(x, x, FRAC);
      sy = scaled_product(y, y, FRAC);
      t = scaled_product(x, y, FRAC - 1);
      y = sat_z(t + ci);
      x = sat_z(sx - sy + cr);
      n++;
    end
    if (n == lim) begin
      r = 0; g = 0; b = 0;
    end else begin
      r = (n * 5) % 255;
      g = (n * 3) % 255;
      b = n % 255;
    end
    r = chan_clamp(r);
    g = chan_clamp(g);
    b = chan_clamp(b);
    yv = ((77 * r + 150 * g + 29 * b) / 256) & 255;
    cbn = (112 * 2 * b - 74 * 2 * g - 38 * 2 * r) / 512 + 128;
    crn = (112 * 2 * r - 94 * 2 * g - 18 * 2 * b) / 512 + 128;
    res.pixel_word = {yv[7:0], cbn[7:0], yv[7:0], crn[7:0]};
    res.iteration_count = n[23:0];
    res.inside_set = (n == lim);
    res.fb_index = 20'(row * words_per_line + col);
    return res;
  endfunction

  always_ff @(posedge clk) begin
    pixel_result_t exp_word;
    if (!rst_n) begin
      quality <= mbe_pkg::QUALITY_RST;
      view_x0 <= longint'(mbe_pkg::X_START_RST);
      view_y0 <= longint'(mbe_pkg::Y_START_RST);
      view_dx <= longint'({33'd0, mbe_pkg::STEP_X_RST});
      view_dy <= longint'({33'd0, mbe_pkg::STEP_Y_RST});
      words_per_line <= mbe_pkg::LINE_WIDTH_RST;
      predicted_pixels.delete();
      failures <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mbe_pkg::CFG_QUALITY:    quality <= cfg_wdata[2:0];
          mbe_pkg::CFG_X_START:    view_x0 <= longint'(signed'(cfg_wdata));
          mbe_pkg::CFG_Y_START:    view_y0 <= longint'(signed'(cfg_wdata));
          mbe_pkg::CFG_STEP_X:     view_dx <= longint'({33'd0, cfg_wdata[30:0]});
          mbe_pkg::CFG_STEP_Y:     view_dy <= longint'({33'd0, cfg_wdata[30:0]});
          mbe_pkg::CFG_LINE_WIDTH: words_per_line <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (start && !busy) predicted_pixels.push_back(escape_pixel(in_pixel_col, in_pixel_row));
      if (out_valid) begin
        if (predicted_pixels.size() == 0) begin
          $error("result word with no pixel pending");
          failures <= failures + 1;
        end else begin
          exp_word = predicted_pixels.pop_front();
          if (out_pixel_word !== exp_word.pixel_word ||
              out_iteration_count !== exp_word.iteration_count ||
              out_inside_set !== exp_word.inside_set ||
              out_fb_index !== exp_word.fb_index)
            failures <= failures + 1;
          if (out_pixel_word !== exp_word.pixel_word)
            $error("pixel_word expected %h got %h", exp_word.pixel_word, out_pixel_word);
          if (out_iteration_count !== exp_word.iteration_count)
            $error("iteration_count expected %0d got %0d", exp_word.iteration_count,
                   out_iteration_count);
          if (out_inside_set !== exp_word.inside_set)
            $error("inside_set expected %b got %b", exp_word.inside_set, out_inside_set);
          if (out_fb_index !== exp_word.fb_index)
            $error("fb_index expected %0d got %0d", exp_word.fb_index, out_fb_index);
        end
      end
      pending <= predicted_pixels.size();
    end
  end

endmodule

[tb/mandelbrot_escape_pixel_unit_test.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit_test
// Drives pixels through the escape unit under a series of views and quality
// levels, with random gaps between pixels, while a checker predicts every
// result word. Views that could run long use the low quality level only.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_unit_test;

  localparam int STALL_LIMIT = 200000;

  logic                           clk, rst_n;
  logic                           cfg_we;
  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           start, busy;
  logic [9:0]                     in_pixel_col, in_pixel_row;
  logic                           out_valid;
  logic [31:0]                    out_pixel_word;
  logic [23:0]                    out_iteration_count;
  logic                           out_inside_set;
  logic [19:0]                    out_fb_index;
  int                             failures, pending;
  int                             quiet_cycles;

  mandelbrot_escape_pixel_unit dut (.*);
  mandelbrot_escape_pixel_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Ends the run when neither a pixel nor a result word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("mandelbrot_escape_pixel_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row, input int gap);
    start <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(input logic [2:0] q, input logic [31:0] x0, input logic [31:0] y0,
                          input logic [31:0] dx, input logic [31:0] dy,
                          input logic [31:0] lw);
    write_reg(mbe_pkg::CFG_QUALITY, {29'd0, q});
    write_reg(mbe_pkg::CFG_X_START, x0);
    write_reg(mbe_pkg::CFG_Y_START, y0);
    write_reg(mbe_pkg::CFG_STEP_X, dx);
    write_reg(mbe_pkg::CFG_STEP_Y, dy);
    write_reg(mbe_pkg::CFG_LINE_WIDTH, lw);
  endtask

  initial begin
    logic [31:0] dx, dy;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default view: corners, the center of the set and a few scattered pixels.
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd0, 10'd1023, 2);
    send_pixel(10'd1023, 10'd0, 0);
    send_pixel(10'd240, 10'd240, 0);
    send_pixel(10'd300, 10'd240, 40);
    send_pixel(10'd341, 10'd682, 0);
    drain();

    // Largest corner, steps and index wrap at the top quality codes.
    set_view(3'd7, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7ff);
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd512, 10'd1, 1);
    drain();
    set_view(3'd4, 32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h0);
    send_pixel(10'd1023, 10'd0, 0);
    send_pixel(10'd5, 10'd1023, 0);
    drain();

    // Origin stays inside; minus two sits on the edge of escape.
    set_view(3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd1);
    send_pixel(10'd7, 10'd9, 0);
    drain();
    write_reg(mbe_pkg::CFG_X_START, 32'he0000000);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd0, 10'd0, 0);
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      if (phase % 2 == 0) begin
        // Random view at the shortest limit; about half keep the steps fine.
        dx = $urandom_range(0, 1) ? ($urandom & 32'h7fffffff) : $urandom_range(0, 1 << 22);
        dy = $urandom_range(0, 1) ? ($urandom & 32'h7fffffff) : $urandom_range(0, 1 << 22);
        set_view(3'd0,
                 $urandom_range(0, 1) ? $urandom : 32'(-$urandom_range(0, 32'h28000000)),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h18000000),
                 dx, dy, $urandom_range(0, 2047));
      end else begin
        // Real part at least 2.5 so every pixel escapes early at any limit.
        set_view(3'($urandom_range(0, 7)), $urandom_range(32'h28000000, 32'h7fffffff),
                 $urandom, $urandom & 32'h7fffffff, $urandom & 32'h7fffffff,
                 $urandom_range(0, 2047));
      end
      for (int i = 0; i < 70; i++)
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   (i > 20 && i < 35) ? 0 : pick_gap());
      drain();
    end

    if (failures == 0 && pending == 0) begin
      $display("mandelbrot_escape_pixel_unit_test: clean");
    end else begin
      $display("mandelbrot_escape_pixel_unit_test: errors");
    end
    $finish;
  end

endmodule
